### hdl/rwpf_pkg.sv
// Package with the types, constants and CRC functions of the register-write packet framer.
package rwpf_pkg;

	localparam int WORD_W      = 32;
	localparam int ADDR_W      = 24;
	localparam int PAIR_W      = 8;
	localparam int CFG_IDX_W   = 8;
	localparam int MAX_PAIRS_DEF   = 255;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [WORD_W-1:0] CRC_SEED = 32'h46AF6449;
	localparam logic [WORD_W-1:0] CRC_POLY = 32'h04C11DB7;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START   = 8'd0,
		CFG_HEADER  = 8'd1,
		CFG_END     = 8'd2,
		CFG_VERSION = 8'd3
	} cfg_idx_t;

	typedef struct packed {
		logic              first;
		logic              last;
		logic [PAIR_W-1:0] cnt;
		logic [WORD_W-1:0] value;
		logic [WORD_W-1:0] addr_word;
	} rwpf_entry_t;

	// Response of the CRC update to a single set bit: bits 0 to 31 of the old CRC,
	// then bits 0 to 31 of the data word. Only ever called with constant arguments.
	function automatic logic [WORD_W-1:0] crc_col(input int j);
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
		logic              top;
		c = (j < WORD_W) ? (32'd1 << j[4:0]) : '0;
		d = (j >= WORD_W) ? (32'd1 << j[4:0]) : '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			top = c[WORD_W-1];
			c   = {c[WORD_W-2:0], d[i]};
			if (top) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// One data word shifted into the CRC, most significant bit first.
	function automatic logic [WORD_W-1:0] crc_word(input logic [WORD_W-1:0] crc,
			input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] r;
		r = '0;
		for (int j = 0; j < WORD_W; j++) begin
			if (crc[j]) begin
				r = r ^ crc_col(j);
			end
			if (w[j]) begin
				r = r ^ crc_col(j + WORD_W);
			end
		end
		return r;
	endfunction

endpackage

### hdl/rwpf_channels.sv
// Interfaces for the item, word and configuration channels of the packet framer.
interface rwpf_item_if;
	import rwpf_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] reg_value;
	logic [ADDR_W-1:0] reg_address;
	logic [PAIR_W-1:0] pair_count;
	modport source (output valid, reg_value, reg_address, pair_count, input ready);
	modport sink (input valid, reg_value, reg_address, pair_count, output ready);
endinterface

interface rwpf_word_if;
	import rwpf_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] out_word;
	logic              last_word;
	modport source (output valid, out_word, last_word, input ready);
	modport sink (input valid, out_word, last_word, output ready);
endinterface

interface rwpf_cfg_if;
	import rwpf_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WORD_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hdl/rwpf_front.sv
// Front end: accepts pairs, tracks packet position and builds the address word.
module rwpf_front #(
	parameter int MAX_PAIRS = rwpf_pkg::MAX_PAIRS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rwpf_item_if.sink             item,
	output logic                  ent_valid,
	input  logic                  ent_ready,
	output rwpf_pkg::rwpf_entry_t ent
);
	import rwpf_pkg::*;

	logic              in_packet_q;
	logic [PAIR_W-1:0] done_q;
	logic [PAIR_W-1:0] total_q;
	logic [PAIR_W-1:0] cnt_sat;
	logic [PAIR_W-1:0] done_nxt;
	logic [PAIR_W-1:0] total_nxt;
	logic [3:0]        par_addr;
	logic [3:0]        par_val;
	logic              accept;

	assign accept     = item.valid && ent_ready;
	assign item.ready = ent_ready;
	assign ent_valid  = item.valid;

	always_comb begin
		cnt_sat = item.pair_count;
		if (cnt_sat == '0) begin
			cnt_sat = PAIR_W'(1);
		end
		if (cnt_sat > PAIR_W'(MAX_PAIRS)) begin
			cnt_sat = PAIR_W'(MAX_PAIRS);
		end
		if (!in_packet_q) begin
			total_nxt = cnt_sat;
			done_nxt  = PAIR_W'(1);
		end else begin
			total_nxt = total_q;
			done_nxt  = done_q + PAIR_W'(1);
		end
	end

	assign par_addr = {1'b0, ^item.reg_address[23:16], ^item.reg_address[15:8],
		^item.reg_address[7:0]};
	assign par_val  = {^item.reg_value[31:24], ^item.reg_value[23:16],
		^item.reg_value[15:8], ^item.reg_value[7:0]};

	always_comb begin
		ent.first     = !in_packet_q;
		ent.last      = (done_nxt >= total_nxt);
		ent.cnt       = total_nxt;
		ent.value     = item.reg_value;
		ent.addr_word = {par_addr, par_val, item.reg_address};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			done_q      <= '0;
			total_q     <= '0;
		end else if (accept) begin
			if (ent.last) begin
				in_packet_q <= 1'b0;
				done_q      <= '0;
			end else begin
				in_packet_q <= 1'b1;
				done_q      <= done_nxt;
			end
			total_q <= total_nxt;
		end
	end

endmodule

### hdl/rwpf_queue.sv
// Short queue of classified pairs between the front end and the word sequencer.
module rwpf_queue #(
	parameter int DEPTH = rwpf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  rwpf_pkg::rwpf_entry_t push_ent,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output rwpf_pkg::rwpf_entry_t pop_ent
);
	import rwpf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rwpf_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_ent    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### hdl/rwpf_back.sv
// Back end: holds the configuration words and emits packet words with the running CRC.
module rwpf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	rwpf_cfg_if.sink              cfg,
	input  logic                  ent_valid,
	output logic                  ent_ready,
	input  rwpf_pkg::rwpf_entry_t ent,
	rwpf_word_if.source           word
);
	import rwpf_pkg::*;

	typedef enum logic [7:0] {
		PH_ENTRY = 8'b0000_0001,
		PH_LEN   = 8'b0000_0010,
		PH_VER   = 8'b0000_0100,
		PH_HDR   = 8'b0000_1000,
		PH_VAL   = 8'b0001_0000,
		PH_ADR   = 8'b0010_0000,
		PH_END   = 8'b0100_0000,
		PH_CRC   = 8'b1000_0000
	} phase_t;

	phase_t            phase_q;
	phase_t            phase_nxt;
	logic [WORD_W-1:0] start_q;
	logic [WORD_W-1:0] header_q;
	logic [WORD_W-1:0] end_q;
	logic [WORD_W-1:0] version_q;
	logic [WORD_W-1:0] crc_q;
	logic [WORD_W-1:0] crc_nxt;
	logic [WORD_W-1:0] crc_in;
	logic [WORD_W-1:0] crc_upd;
	logic [WORD_W-1:0] word_nxt;
	logic              last_nxt;
	logic              crc_en;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	logic              out_last_q;
	logic              load;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			header_q  <= '0;
			end_q     <= '0;
			version_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_START:   start_q   <= cfg.data;
				CFG_HEADER:  header_q  <= cfg.data;
				CFG_END:     end_q     <= cfg.data;
				CFG_VERSION: version_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign load = ent_valid && (!out_valid_q || word.ready);

	always_comb begin
		phase_nxt = phase_q;
		word_nxt  = ent.value;
		last_nxt  = 1'b0;
		crc_en    = 1'b0;
		crc_in    = ent.value;
		ent_ready = 1'b0;
		case (phase_q)
			PH_ENTRY: begin
				if (ent.first) begin
					word_nxt  = start_q;
					phase_nxt = PH_LEN;
				end else begin
					crc_en    = 1'b1;
					phase_nxt = PH_ADR;
				end
			end
			PH_LEN: begin
				word_nxt  = {23'd0, ent.cnt, 1'b0} + 32'd5;
				phase_nxt = PH_VER;
			end
			PH_VER: begin
				word_nxt  = version_q;
				crc_in    = version_q;
				crc_en    = 1'b1;
				phase_nxt = PH_HDR;
			end
			PH_HDR: begin
				word_nxt  = header_q;
				crc_in    = header_q;
				crc_en    = 1'b1;
				phase_nxt = PH_VAL;
			end
			PH_VAL: begin
				crc_en    = 1'b1;
				phase_nxt = PH_ADR;
			end
			PH_ADR: begin
				word_nxt = ent.addr_word;
				crc_in   = ent.addr_word;
				crc_en   = 1'b1;
				if (ent.last) begin
					phase_nxt = PH_END;
				end else begin
					last_nxt  = 1'b1;
					ent_ready = load;
					phase_nxt = PH_ENTRY;
				end
			end
			PH_END: begin
				word_nxt  = end_q;
				phase_nxt = PH_CRC;
			end
			PH_CRC: begin
				word_nxt  = crc_word(crc_q, '0);
				last_nxt  = 1'b1;
				ent_ready = load;
				phase_nxt = PH_ENTRY;
			end
			default: begin
				phase_nxt = PH_ENTRY;
			end
		endcase
	end

	assign crc_upd = crc_word(crc_q, crc_in);

	always_comb begin
		crc_nxt = crc_q;
		if (phase_q == PH_ENTRY && ent.first) begin
			crc_nxt = CRC_SEED;
		end else if (crc_en) begin
			crc_nxt = crc_upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_ENTRY;
			crc_q       <= CRC_SEED;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q     <= phase_nxt;
				crc_q       <= crc_nxt;
				out_valid_q <= 1'b1;
			end else if (word.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_word_q <= word_nxt;
			out_last_q <= last_nxt;
		end
	end

	assign word.valid     = out_valid_q;
	assign word.out_word  = out_word_q;
	assign word.last_word = out_last_q;

endmodule

### hdl/register_write_packet_framer_top.sv
// Top level of the register-write packet framer.
//
//   Port   Direction  Transaction
//   item   sink       one register-write pair (value, address, pair count)
//   word   source     one packet word, last_word set on the final word of a pair
//   cfg    sink       write of start, header, end or version word by index
//
// Each pair yields two words; while they go out, the queue takes more pairs until
// it is full. The first pair of a packet adds four words and the last adds two.
// The single registered word output sets the pace at which pairs are taken.
// A pair is written into a short queue at the edge that accepts it, and its first
// word passes from the queue into the output register before it can be taken; reset
// clears all control state and the configuration words. Stalls on the word channel
// back up into the queue before the item channel drops ready.
module register_write_packet_framer_top #(
	parameter int MAX_PAIRS   = rwpf_pkg::MAX_PAIRS_DEF,
	parameter int QUEUE_DEPTH = rwpf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rwpf_item_if.sink   item,
	rwpf_word_if.source word,
	rwpf_cfg_if.sink    cfg
);
	import rwpf_pkg::*;

	logic        fr_valid;
	logic        fr_ready;
	rwpf_entry_t fr_ent;
	logic        bk_valid;
	logic        bk_ready;
	rwpf_entry_t bk_ent;

	rwpf_front #(
		.MAX_PAIRS(MAX_PAIRS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.ent_valid (fr_valid),
		.ent_ready (fr_ready),
		.ent       (fr_ent)
	);

	rwpf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_ent   (fr_ent),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_ent    (bk_ent)
	);

	rwpf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.ent_valid (bk_valid),
		.ent_ready (bk_ready),
		.ent       (bk_ent),
		.word      (word)
	);

endmodule

### tb/tb_top.sv
// Self-checking testbench for the register-write packet framer with randomized flow control.
`timescale 1ns / 1ps

module tb_top;
	import rwpf_pkg::*;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic [ADDR_W-1:0] addr;
		logic [PAIR_W-1:0] cnt;
	} reg_pair_t;

	typedef struct packed {
		logic [WORD_W-1:0] data;
		logic              last;
	} packet_word_t;

	typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW = 8'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP = 8'hFF;
	localparam int RANDOM_PAIRS = 400;
	localparam int LONG_HOLD    = 300;

	logic clk = 1'b0;
	logic arst_n;

	rwpf_item_if item_ch();
	rwpf_word_if word_ch();
	rwpf_cfg_if  cfg_ch();

	register_write_packet_framer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.word   (word_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	reg_pair_t    pair_queue[$];
	packet_word_t packet_words_due[$];
	reg_pair_t    next_pair;

	logic [WORD_W-1:0] start_reg;
	logic [WORD_W-1:0] header_reg;
	logic [WORD_W-1:0] end_reg;
	logic [WORD_W-1:0] version_reg;
	logic [WORD_W-1:0] crc_acc;
	logic [PAIR_W-1:0] pkt_done;
	logic [PAIR_W-1:0] pkt_total;
	logic              pkt_open;

	int pairs_accepted = 0;
	int packets_framed = 0;
	int words_checked  = 0;
	int reg_writes     = 0;
	int mismatches     = 0;
	int burst_left     = 1;
	int gap_left       = 0;
	int stall_win      = 0;
	rx_mode_t stall_mode = RX_OPEN;
	logic hold_off;

	function automatic logic [WORD_W-1:0] crc32_shift(input logic [WORD_W-1:0] crc,
			input logic [WORD_W-1:0] w);
		logic top;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			top = crc[WORD_W-1];
			crc = {crc[WORD_W-2:0], w[i]};
			if (top) begin
				crc = crc ^ CRC_POLY;
			end
		end
		return crc;
	endfunction

	function automatic logic [3:0] byte_odd(input logic [WORD_W-1:0] w);
		return {^w[31:24], ^w[23:16], ^w[15:8], ^w[7:0]};
	endfunction

	function automatic void due_word(input logic [WORD_W-1:0] data, input logic last);
		packet_word_t pw;
		pw.data = data;
		pw.last = last;
		packet_words_due.push_back(pw);
	endfunction

	function automatic void frame_pair(input logic [WORD_W-1:0] value,
			input logic [ADDR_W-1:0] addr, input logic [PAIR_W-1:0] cnt);
		logic [PAIR_W-1:0] total;
		logic [WORD_W-1:0] addr_word;
		logic              closes;
		if (!pkt_open) begin
			total = (cnt == '0) ? 8'd1 : cnt;
			if (int'(total) > MAX_PAIRS_DEF) begin
				total = MAX_PAIRS_DEF[PAIR_W-1:0];
			end
			pkt_total = total;
			pkt_done  = '0;
			crc_acc   = CRC_SEED;
			due_word(start_reg, 1'b0);
			due_word(32'(total) * 2 + 5, 1'b0);
			due_word(version_reg, 1'b0);
			crc_acc = crc32_shift(crc_acc, version_reg);
			due_word(header_reg, 1'b0);
			crc_acc = crc32_shift(crc_acc, header_reg);
			pkt_open = 1'b1;
		end
		addr_word = {byte_odd({8'd0, addr}), byte_odd(value), addr};
		pkt_done  = pkt_done + 1'b1;
		closes    = (pkt_done >= pkt_total);
		due_word(value, 1'b0);
		crc_acc = crc32_shift(crc_acc, value);
		due_word(addr_word, !closes);
		crc_acc = crc32_shift(crc_acc, addr_word);
		if (closes) begin
			due_word(end_reg, 1'b0);
			crc_acc = crc32_shift(crc_acc, '0);
			due_word(crc_acc, 1'b1);
			pkt_open = 1'b0;
			pkt_done = '0;
			packets_framed++;
		end
	endfunction

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				frame_pair(item_ch.reg_value, item_ch.reg_address, item_ch.pair_count);
				pairs_accepted++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					item_ch.valid <= 1'b0;
				end else if (pair_queue.size() > 0) begin
					next_pair = pair_queue.pop_front();
					item_ch.reg_value   <= next_pair.value;
					item_ch.reg_address <= next_pair.addr;
					item_ch.pair_count  <= next_pair.cnt;
					item_ch.valid       <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: the stall pattern changes at the end of each randomly sized window.
	always @(posedge clk) begin
		if (stall_win == 0) begin
			stall_mode <= rx_mode_t'($urandom_range(0, 3));
			stall_win  <= $urandom_range(20, 80);
		end else begin
			stall_win <= stall_win - 1;
		end
		if (hold_off) begin
			word_ch.ready <= 1'b0;
		end else begin
			case (stall_mode)
				RX_OPEN:   word_ch.ready <= 1'b1;
				RX_LIGHT:  word_ch.ready <= ($urandom_range(0, 3) != 0);
				RX_HEAVY:  word_ch.ready <= ($urandom_range(0, 3) == 0);
				RX_TOGGLE: word_ch.ready <= !word_ch.ready;
				default:   word_ch.ready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		packet_word_t due;
		if (arst_n && word_ch.valid && word_ch.ready) begin
			if (packet_words_due.size() == 0) begin
				if (mismatches < 10) begin
					$display("tb_top: unexpected word %h last %b", word_ch.out_word,
						word_ch.last_word);
				end
				mismatches++;
			end else begin
				due = packet_words_due.pop_front();
				if (word_ch.out_word !== due.data || word_ch.last_word !== due.last) begin
					if (mismatches < 10) begin
						$display("tb_top: word %0d expected %h last %b, got %h last %b",
							words_checked, due.data, due.last, word_ch.out_word,
							word_ch.last_word);
					end
					mismatches++;
				end
			end
			words_checked++;
		end
	end

	// The output side holds off long enough for the block to back up into the item channel.
	initial begin
		hold_off = 1'b0;
		wait (pairs_accepted >= 60);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#1000000;
		$display("tb_top: FAIL");
		$finish;
	end

	task automatic add_pair(input logic [WORD_W-1:0] value, input logic [ADDR_W-1:0] addr,
			input logic [PAIR_W-1:0] cnt);
		reg_pair_t p;
		p.value = value;
		p.addr  = addr;
		p.cnt   = cnt;
		pair_queue.push_back(p);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready) begin
			@(posedge clk);
		end
		case (idx)
			CFG_START:   start_reg   = data;
			CFG_HEADER:  header_reg  = data;
			CFG_END:     end_reg     = data;
			CFG_VERSION: version_reg = data;
			default: ;
		endcase
		reg_writes++;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain_block();
		do begin
			@(negedge clk);
		end while (pair_queue.size() != 0 || item_ch.valid || packet_words_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic randomize_regs();
		write_reg(CFG_START, rand_word());
		write_reg(CFG_HEADER, rand_word());
		write_reg(CFG_END, rand_word());
		write_reg(CFG_VERSION, rand_word());
		if ($urandom_range(0, 2) == 0) begin
			write_reg(8'($urandom_range(int'(CFG_UNUSED_LOW), int'(CFG_UNUSED_TOP))), $urandom);
		end
	endtask

	initial begin
		int                random_pairs;
		int                pkt_left;
		int                phase_len;
		int                r;
		logic              big_done;
		logic [PAIR_W-1:0] cnt;
		logic [WORD_W-1:0] addr_rand;
		random_pairs = 0;
		pkt_left     = 0;
		big_done     = 1'b0;
		start_reg    = '0;
		header_reg   = '0;
		end_reg      = '0;
		version_reg  = '0;
		crc_acc      = CRC_SEED;
		pkt_done     = '0;
		pkt_total    = '0;
		pkt_open     = 1'b0;
		arst_n              = 1'b0;
		item_ch.valid       = 1'b0;
		item_ch.reg_value   = '0;
		item_ch.reg_address = '0;
		item_ch.pair_count  = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;
		word_ch.ready       = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Packet with the registers at their reset values.
		add_pair(32'h0, 24'h0, 8'd1);
		drain_block();
		write_reg(CFG_START, '1);
		write_reg(CFG_HEADER, '1);
		write_reg(CFG_END, '1);
		write_reg(CFG_VERSION, '1);
		write_reg(CFG_UNUSED_LOW, 32'h0);
		write_reg(CFG_UNUSED_TOP, 32'h1234_5678);

		add_pair(32'hFFFF_FFFF, 24'hFF_FFFF, 8'd0);
		add_pair(32'h0000_0000, 24'hFF_FFFF, 8'd2);
		add_pair(32'hFFFF_FFFF, 24'h00_0000, 8'hFF);
		add_pair(32'h8000_0000, 24'h80_0000, 8'd1);
		add_pair(32'h0000_0001, 24'h00_0001, 8'd1);
		add_pair(32'hA5A5_A5A5, 24'h5A_5A5A, 8'd3);
		add_pair(32'h0101_0101, 24'h01_0101, 8'd0);
		drain_block();
		// The open packet picks up the new end word on its last pair.
		write_reg(CFG_START, 32'h1357_9BDF);
		write_reg(CFG_HEADER, 32'h2468_ACE0);
		write_reg(CFG_END, 32'h0);
		write_reg(CFG_VERSION, 32'h0);
		add_pair(32'h7F7F_7F7F, 24'h7F_7F7F, 8'h80);
		add_pair(32'hFEDC_BA98, 24'h12_3456, 8'd2);
		add_pair(32'h00FF_00FF, 24'hFF_00FF, 8'd0);
		drain_block();

		phase_len = 100;
		while (random_pairs < RANDOM_PAIRS || pkt_left > 0) begin
			for (int n = 0; n < phase_len && (random_pairs < RANDOM_PAIRS || pkt_left > 0);
					n++) begin
				if (pkt_left == 0) begin
					r = $urandom_range(0, 19);
					if (!big_done && random_pairs >= 120) begin
						cnt      = 8'hFF;
						big_done = 1'b1;
					end else if (r == 0) begin
						cnt = 8'd0;
					end else if (r == 1) begin
						cnt = 8'($urandom_range(20, 60));
					end else begin
						cnt = 8'($urandom_range(1, 6));
					end
					pkt_left = (cnt == '0) ? 1 : int'(cnt);
				end else begin
					cnt = 8'($urandom);
				end
				addr_rand = rand_word();
				add_pair(rand_word(), addr_rand[ADDR_W-1:0], cnt);
				pkt_left--;
				random_pairs++;
			end
			drain_block();
			randomize_regs();
			phase_len = $urandom_range(20, 50);
		end

		drain_block();
		repeat (20) @(negedge clk);
		if (packet_words_due.size() != 0) begin
			mismatches++;
		end
		$display("tb_top: %0d pairs framed into %0d packets, %0d words checked",
			pairs_accepted, packets_framed, words_checked);
		$display("tb_top: %0d register writes, one %0d-cycle output hold-off",
			reg_writes, LONG_HOLD);
		if (mismatches == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

### files.f
hdl/rwpf_pkg.sv
hdl/rwpf_channels.sv
hdl/rwpf_front.sv
hdl/rwpf_queue.sv
hdl/rwpf_back.sv
hdl/register_write_packet_framer_top.sv
tb/tb_top.sv
